>>> sv/ssbf_pkg.sv
`default_nettype none

package ssbf_pkg;

  // Field widths fixed by the interface
  localparam int ENTROPY_BITS      = 16;
  localparam int OUT_POS_BITS      = 24;
  localparam int CNT_BITS          = 16;
  localparam int THRESH_BITS       = 16;
  localparam int RUN_CFG_BITS      = 8;
  localparam int HOP_BITS          = 13;
  localparam int WINDOW_BITS       = 14;
  localparam int CFG_INDEX_BITS    = 3;
  localparam int CFG_DATA_BITS     = 16;
  localparam int POSITION_BITS_DEF = 24;

  // Register reset values
  localparam logic [THRESH_BITS-1:0]  THRESH_RST  = 16'd0;
  localparam logic [RUN_CFG_BITS-1:0] MIN_RUN_RST = 8'd3;
  localparam logic [RUN_CFG_BITS-1:0] MAX_GAP_RST = 8'd3;
  localparam logic [HOP_BITS-1:0]     HOP_RST     = 13'd256;
  localparam logic [WINDOW_BITS-1:0]  WINDOW_RST  = 14'd512;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_MIN_RUN   = 3'd1,
    CFG_MAX_GAP   = 3'd2,
    CFG_HOP       = 3'd3,
    CFG_WINDOW    = 3'd4
  } cfg_idx_t;

  // One input beat
  typedef struct packed {
    logic [ENTROPY_BITS-1:0] frame_entropy;
    logic                    last_frame;
  } in_t;

  // One result beat
  typedef struct packed {
    logic [OUT_POS_BITS-1:0] segment_start;
    logic [OUT_POS_BITS-1:0] segment_end;
  } out_t;

  // Saturating increment of a frame counter
  function automatic logic [CNT_BITS-1:0] cnt_sat_inc(input logic [CNT_BITS-1:0] v);
    return (&v) ? v : v + CNT_BITS'(1);
  endfunction

endpackage

`default_nettype wire

>>> sv/ssbf_pos_calc.sv
`default_nettype none

// Sample positions of the current frame: start = index * hop and
// end = (index - 1) * hop + window, both saturating at all ones.
module ssbf_pos_calc #(
  parameter int POSITION_BITS = ssbf_pkg::POSITION_BITS_DEF
) (
  input  wire logic [POSITION_BITS-1:0]         frame_index,
  input  wire logic [ssbf_pkg::HOP_BITS-1:0]    hop_samples,
  input  wire logic [ssbf_pkg::WINDOW_BITS-1:0] window_samples,
  output logic      [POSITION_BITS-1:0]         start_cand,
  output logic      [POSITION_BITS-1:0]         end_cand
);
  import ssbf_pkg::*;

  localparam int PROD_W = POSITION_BITS + HOP_BITS;

  logic [PROD_W-1:0]        prod;
  logic [PROD_W-1:0]        prev_prod;
  logic [POSITION_BITS-1:0] prev_sat;
  logic [POSITION_BITS:0]   end_sum;

  // One product serves both positions: the previous frame sits one hop lower.
  assign prod      = PROD_W'(frame_index) * PROD_W'(hop_samples);
  assign prev_prod = (frame_index == '0) ? '0 : prod - PROD_W'(hop_samples);

  assign start_cand = (|prod[PROD_W-1:POSITION_BITS]) ? '1 : prod[POSITION_BITS-1:0];
  assign prev_sat   = (|prev_prod[PROD_W-1:POSITION_BITS]) ? '1
                                                           : prev_prod[POSITION_BITS-1:0];

  // Add the window and clamp again.
  assign end_sum  = {1'b0, prev_sat} + (POSITION_BITS+1)'(window_samples);
  assign end_cand = end_sum[POSITION_BITS] ? '1 : end_sum[POSITION_BITS-1:0];

endmodule

`default_nettype wire

>>> sv/speech_segment_boundary_finder.sv
`default_nettype none

// Entropy-driven speech segment finder. Each input beat carries one frame
// entropy and a last-frame flag; a frame is active when its entropy is above
// the threshold. The block accepts one beat per clock while in_ready is high
// and updates its run, gap and position state in that same cycle, so a
// result appears on out_* in the cycle after the beat that closes a segment
// (at most one result per beat). The critical path is the index-by-hop
// multiplier followed by the end-position add and clamp. in_ready stays high
// while the result register is empty or being drained, so back-to-back beats
// flow at one per cycle. Configuration is taken at any time over cfg_*, but
// should only be written while the block is idle.
module speech_segment_boundary_finder #(
  parameter int POSITION_BITS = ssbf_pkg::POSITION_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire ssbf_pkg::in_t                   in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output ssbf_pkg::out_t                       out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ssbf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [ssbf_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import ssbf_pkg::*;

  // Configuration registers
  logic [THRESH_BITS-1:0]  thresh_r;
  logic [RUN_CFG_BITS-1:0] min_run_r;
  logic [RUN_CFG_BITS-1:0] max_gap_r;
  logic [HOP_BITS-1:0]     hop_r;
  logic [WINDOW_BITS-1:0]  window_r;

  // Segment state
  logic [POSITION_BITS-1:0] frame_idx_r, frame_idx_nxt;
  logic [CNT_BITS-1:0]      run_len_r, run_len_nxt;
  logic [CNT_BITS-1:0]      gap_cnt_r, gap_cnt_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;
  logic [POSITION_BITS-1:0] end_r, end_nxt;

  // Result register
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;

  logic                     in_fire;
  logic                     active;
  logic                     emit;
  logic [CNT_BITS-1:0]      gap_inc;
  logic [POSITION_BITS-1:0] end_upd;
  logic [POSITION_BITS-1:0] start_cand;
  logic [POSITION_BITS-1:0] end_cand;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ssbf_pos_calc #(
    .POSITION_BITS(POSITION_BITS)
  ) u_pos_calc (
    .frame_index   (frame_idx_r),
    .hop_samples   (hop_r),
    .window_samples(window_r),
    .start_cand    (start_cand),
    .end_cand      (end_cand)
  );

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r  <= THRESH_RST;
      min_run_r <= MIN_RUN_RST;
      max_gap_r <= MAX_GAP_RST;
      hop_r     <= HOP_RST;
      window_r  <= WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESHOLD: thresh_r  <= cfg_wdata[THRESH_BITS-1:0];
        CFG_MIN_RUN:   min_run_r <= cfg_wdata[RUN_CFG_BITS-1:0];
        CFG_MAX_GAP:   max_gap_r <= cfg_wdata[RUN_CFG_BITS-1:0];
        CFG_HOP:       hop_r     <= cfg_wdata[HOP_BITS-1:0];
        CFG_WINDOW:    window_r  <= cfg_wdata[WINDOW_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Frame classification and segment bookkeeping for the incoming beat.
  always_comb begin
    active  = in_data.frame_entropy[ENTROPY_BITS-1:0] > thresh_r[ENTROPY_BITS-1:0];
    gap_inc = cnt_sat_inc(gap_cnt_r);
    end_upd = (run_len_r > CNT_BITS'(min_run_r)) ? end_cand : end_r;
    emit    = 1'b0;

    frame_idx_nxt = (&frame_idx_r) ? frame_idx_r : frame_idx_r + POSITION_BITS'(1);
    run_len_nxt   = run_len_r;
    gap_cnt_nxt   = gap_cnt_r;
    start_nxt     = start_r;
    end_nxt       = end_r;

    if (active) begin
      run_len_nxt = cnt_sat_inc(run_len_r);
      gap_cnt_nxt = '0;
      if (start_r == '0) begin
        start_nxt = start_cand;
      end
    end else begin
      run_len_nxt = '0;
      gap_cnt_nxt = gap_inc;
      emit        = (gap_inc >= CNT_BITS'(max_gap_r) || in_data.last_frame) &&
                    start_r != '0 && end_upd != '0;
      // A gap long enough closes the segment and forgets its bounds.
      if (gap_inc >= CNT_BITS'(max_gap_r)) begin
        start_nxt = '0;
        end_nxt   = '0;
      end else begin
        end_nxt = end_upd;
      end
    end

    // The last frame ends the signal: the next beat starts afresh.
    if (in_data.last_frame) begin
      frame_idx_nxt = '0;
      run_len_nxt   = '0;
      gap_cnt_nxt   = '0;
      start_nxt     = '0;
      end_nxt       = '0;
    end

    if (in_fire) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_idx_r <= '0;
      run_len_r   <= '0;
      gap_cnt_r   <= '0;
      start_r     <= '0;
      end_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        frame_idx_r <= frame_idx_nxt;
        run_len_r   <= run_len_nxt;
        gap_cnt_r   <= gap_cnt_nxt;
        start_r     <= start_nxt;
        end_r       <= end_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_data_r.segment_start <= OUT_POS_BITS'(start_r);
      out_data_r.segment_end   <= OUT_POS_BITS'(end_upd);
    end
  end

endmodule

`default_nettype wire

>>> sv/ssbf_checker.sv
`default_nettype none

// Port-level checks for the segment finder.
module ssbf_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire ssbf_pkg::out_t out_data
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // With the result register full and stalled, no new beat may enter.
  a_in_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result register blocked");

  // A new result only follows an accepted input beat.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without an input beat");

  // An empty result register never blocks the input.
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no pending result");

endmodule

bind speech_segment_boundary_finder ssbf_checker u_ssbf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

`default_nettype wire
